// File: rtl/q2e_pkg.sv
// ----------------------------------------------------------------------------
// q2e_pkg
// Shared types, constants and the arctangent table for the quaternion to
// Euler angle converter.
// ----------------------------------------------------------------------------
package q2e_pkg;

  localparam int ANGLE_ITER_DEF = 16;
  localparam int SQRT_STAGES    = 31;   // one result bit per stage
  localparam int OP_W           = 34;   // atan2 operand width
  localparam int ACC_W          = 34;   // angle accumulator, 2^31 = pi

  localparam logic [14:0] THRESH_RESET = 15'd32765;

  // register index (paddr[2])
  localparam logic REG_DIRECTION = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

  // side data carried alongside the square root
  typedef struct packed {
    logic signed [31:0]     s;
    logic signed [OP_W-1:0] hy;
    logic signed [OP_W-1:0] hx;
    logic signed [OP_W-1:0] by;
    logic signed [OP_W-1:0] bx;
    logic                   lock;
    logic signed [15:0]     plock;
  } side_t;

  typedef struct packed {
    logic               lock;
    logic signed [15:0] plock;
  } lock_t;

  // atan(2^-i), 2^31 = pi
  function automatic logic [31:0] atan_entry(input int unsigned i);
    logic [31:0] v;
    case (i)
      0:  v = 32'h20000000;
      1:  v = 32'h12E4051E;
      2:  v = 32'h09FB385B;
      3:  v = 32'h051111D4;
      4:  v = 32'h028B0D43;
      5:  v = 32'h0145D7E1;
      6:  v = 32'h00A2F61E;
      7:  v = 32'h00517C55;
      8:  v = 32'h0028BE53;
      9:  v = 32'h00145F2F;
      10: v = 32'h000A2F98;
      11: v = 32'h000517CC;
      12: v = 32'h00028BE6;
      13: v = 32'h000145F3;
      14: v = 32'h0000A2FA;
      15: v = 32'h0000517D;
      16: v = 32'h000028BE;
      17: v = 32'h0000145F;
      18: v = 32'h00000A30;
      19: v = 32'h00000518;
      20: v = 32'h0000028C;
      21: v = 32'h00000146;
      22: v = 32'h000000A3;
      23: v = 32'h00000051;
      default: v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

// File: rtl/q2e_sqrt.sv
// ----------------------------------------------------------------------------
// q2e_sqrt
// Pipelined floor square root of a 61-bit radicand, one root bit per stage.
// ----------------------------------------------------------------------------
module q2e_sqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [60:0] rad,
  output logic [30:0] root
);
  import q2e_pkg::*;

  logic [60:0] rem_r  [0:SQRT_STAGES-1];
  logic [30:0] root_r [0:SQRT_STAGES-1];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam int B = SQRT_STAGES - 1 - k;
    logic [60:0] rem_in;
    logic [30:0] root_in;
    logic [61:0] trial;

    if (k == 0) begin : g_first
      assign rem_in  = rad;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem_r[k-1];
      assign root_in = root_r[k-1];
    end

    // (root + 2^B)^2 - root^2
    assign trial = ({31'b0, root_in} << (B + 1)) | (62'd1 << (2 * B));

    always_ff @(posedge clk) begin
      if (en) begin
        if ({1'b0, rem_in} >= trial) begin
          rem_r[k]  <= 61'({1'b0, rem_in} - trial);
          root_r[k] <= root_in | (31'd1 << B);
        end else begin
          rem_r[k]  <= rem_in;
          root_r[k] <= root_in;
        end
      end
    end
  end

  assign root = root_r[SQRT_STAGES-1];

endmodule

// File: rtl/q2e_cordic.sv
// ----------------------------------------------------------------------------
// q2e_cordic
// Unrolled vectoring CORDIC: atan2(y, x) as a 16-bit binary angle.
// ----------------------------------------------------------------------------
module q2e_cordic #(
  parameter int ITER = q2e_pkg::ANGLE_ITER_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [q2e_pkg::OP_W-1:0] y_in,
  input  logic signed [q2e_pkg::OP_W-1:0] x_in,
  output logic signed [15:0]              angle
);
  import q2e_pkg::*;

  localparam int XW = OP_W + 3;
  localparam logic signed [ACC_W-1:0] QUARTER = ACC_W'(1) <<< 30;

  logic signed [XW-1:0]    x_r   [0:ITER];
  logic signed [XW-1:0]    y_r   [0:ITER];
  logic signed [ACC_W-1:0] acc_r [0:ITER];
  logic                    zero_r [0:ITER];
  logic signed [15:0]      angle_r;

  logic signed [XW-1:0]    xe, ye, x0_nxt, y0_nxt;
  logic signed [ACC_W-1:0] a0_nxt, rnd;

  // fold the left half plane into the right one
  always_comb begin
    xe = XW'(x_in);
    ye = XW'(y_in);
    if (x_in < 0) begin
      if (y_in >= 0) begin
        x0_nxt = ye;
        y0_nxt = -xe;
        a0_nxt = QUARTER;
      end else begin
        x0_nxt = -ye;
        y0_nxt = xe;
        a0_nxt = -QUARTER;
      end
    end else begin
      x0_nxt = xe;
      y0_nxt = ye;
      a0_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]    <= x0_nxt;
      y_r[0]    <= y0_nxt;
      acc_r[0]  <= a0_nxt;
      zero_r[0] <= (x_in == 0) && (y_in == 0);
    end
  end

  for (genvar k = 0; k < ITER; k++) begin : g_iter
    localparam logic signed [ACC_W-1:0] TBL = ACC_W'(atan_entry(k));
    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[k+1] <= zero_r[k];
        if (y_r[k] < 0) begin
          x_r[k+1]   <= x_r[k] - (y_r[k] >>> k);
          y_r[k+1]   <= y_r[k] + (x_r[k] >>> k);
          acc_r[k+1] <= acc_r[k] - TBL;
        end else begin
          x_r[k+1]   <= x_r[k] + (y_r[k] >>> k);
          y_r[k+1]   <= y_r[k] - (x_r[k] >>> k);
          acc_r[k+1] <= acc_r[k] + TBL;
        end
      end
    end
  end

  assign rnd = acc_r[ITER] + ACC_W'(32768);

  always_ff @(posedge clk) begin
    if (en) begin
      angle_r <= zero_r[ITER] ? 16'sd0 : $signed(rnd[31:16]);
    end
  end

  assign angle = angle_r;

endmodule

// File: rtl/quaternion_to_euler_angles.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// Unit quaternion (Q1.15) to pitch, heading and bank binary angles.
//
//   channel  ports                          moves
//   in       in_valid / in_stall            one quaternion request
//   out      out_valid / out_stall          pitch, heading, bank, lock flag
//   cfg      psel penable pwrite paddr ...  direction, lock threshold
//
// One request per cycle while the output is not stalled. The pipeline holds
// six front stages (capture, products, sums, clamp, square, radicand), 31
// square root stages, the unrolled CORDIC and the output register.
// rst_n is synchronous; it clears the valid bits and the config registers.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
  parameter int ANGLE_ITERATIONS = q2e_pkg::ANGLE_ITER_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_pitch_angle,
  output logic signed [15:0] out_heading_angle,
  output logic signed [15:0] out_bank_angle,
  output logic               out_gimbal_lock,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import q2e_pkg::*;

  localparam int CORDIC_LAT = ANGLE_ITERATIONS + 2;
  localparam int LAT        = 6 + SQRT_STAGES + CORDIC_LAT + 1;
  localparam logic signed [OP_W-1:0] HALF = OP_W'(1) <<< 29;
  localparam logic signed [OP_W-1:0] ONE  = OP_W'(1) <<< 30;

  // ---------------- configuration ----------------
  logic        direction_r;
  logic [14:0] thresh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      direction_r <= 1'b0;
      thresh_r    <= THRESH_RESET;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_DIRECTION: direction_r <= pwdata[0];
        REG_THRESHOLD: thresh_r    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_DIRECTION: prdata = {31'b0, direction_r};
      REG_THRESHOLD: prdata = {17'b0, thresh_r};
      default:       prdata = '0;
    endcase
  end

  assign pready = 1'b1;

  // ---------------- flow control ----------------
  logic [LAT-1:0] valid_r;
  logic           en;

  assign en       = !(valid_r[LAT-1] && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= {valid_r[LAT-2:0], in_valid};
    end
  end

  // ---------------- stage 1: capture ----------------
  logic signed [15:0] w1_r, x1_r, y1_r, z1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      w1_r <= in_quat_w;
      x1_r <= in_quat_x;
      y1_r <= in_quat_y;
      z1_r <= in_quat_z;
    end
  end

  // ---------------- stage 2: products ----------------
  logic signed [31:0] wx2_r, wy2_r, wz2_r, xy2_r, xz2_r, yz2_r, xx2_r, yy2_r, zz2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      wx2_r <= w1_r * x1_r;
      wy2_r <= w1_r * y1_r;
      wz2_r <= w1_r * z1_r;
      xy2_r <= x1_r * y1_r;
      xz2_r <= x1_r * z1_r;
      yz2_r <= y1_r * z1_r;
      xx2_r <= x1_r * x1_r;
      yy2_r <= y1_r * y1_r;
      zz2_r <= z1_r * z1_r;
    end
  end

  // ---------------- stage 3: sine and atan2 operands ----------------
  logic signed [OP_W-1:0] s3_r, hyl3_r, hyn3_r, hxl3_r, hxn3_r, by3_r, bx3_r;
  logic signed [OP_W-1:0] s3_nxt, hyl3_nxt, hyn3_nxt, by3_nxt;
  logic signed [OP_W-1:0] ewx, ewy, ewz, exy, exz, eyz;

  always_comb begin
    ewx = OP_W'(wx2_r);
    ewy = OP_W'(wy2_r);
    ewz = OP_W'(wz2_r);
    exy = OP_W'(xy2_r);
    exz = OP_W'(xz2_r);
    eyz = OP_W'(yz2_r);
    if (direction_r) begin
      s3_nxt   = -((eyz + ewx) <<< 1);
      hyl3_nxt = -exz - ewy;
      hyn3_nxt = exz - ewy;
      by3_nxt  = exy - ewz;
    end else begin
      s3_nxt   = -((eyz - ewx) <<< 1);
      hyl3_nxt = ewy - exz;
      hyn3_nxt = exz + ewy;
      by3_nxt  = exy + ewz;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_r   <= s3_nxt;
      hyl3_r <= hyl3_nxt;
      hyn3_r <= hyn3_nxt;
      hxl3_r <= HALF - OP_W'(yy2_r) - OP_W'(zz2_r);
      hxn3_r <= HALF - OP_W'(xx2_r) - OP_W'(yy2_r);
      by3_r  <= by3_nxt;
      bx3_r  <= HALF - OP_W'(xx2_r) - OP_W'(zz2_r);
    end
  end

  // ---------------- stage 4: clamp, lock test ----------------
  side_t                  side4_nxt, side4_r;
  logic signed [OP_W-1:0] sat4;
  logic [30:0]            mag4_nxt, mag4_r;

  always_comb begin
    if (s3_r > ONE) begin
      sat4 = ONE;
    end else if (s3_r < -ONE) begin
      sat4 = -ONE;
    end else begin
      sat4 = s3_r;
    end
    mag4_nxt        = (sat4 < 0) ? 31'(-sat4) : 31'(sat4);
    side4_nxt.s     = 32'(sat4);
    side4_nxt.lock  = mag4_nxt > {1'b0, thresh_r, 15'b0};
    side4_nxt.hy    = side4_nxt.lock ? hyl3_r : hyn3_r;
    side4_nxt.hx    = side4_nxt.lock ? hxl3_r : hxn3_r;
    side4_nxt.by    = by3_r;
    side4_nxt.bx    = bx3_r;
    side4_nxt.plock = '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side4_nxt;
      mag4_r  <= mag4_nxt;
    end
  end

  // ---------------- stage 5: square, locked pitch ----------------
  logic [61:0] sq5_r;
  side_t       side5_nxt, side5_r;
  logic [31:0] p5;

  always_comb begin
    // (pi/2)*s rounded half away from zero
    p5              = 32'(mag4_r) + 32'd32768;
    side5_nxt       = side4_r;
    side5_nxt.plock = (side4_r.s < 0) ? -$signed(p5[31:16]) : $signed(p5[31:16]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq5_r   <= 62'(mag4_r) * 62'(mag4_r);
      side5_r <= side5_nxt;
    end
  end

  // ---------------- stage 6: radicand ----------------
  logic [60:0] rad6_r;
  side_t       side6_r;

  always_ff @(posedge clk) begin
    if (en) begin
      rad6_r  <= 61'((62'd1 << 60) - sq5_r);
      side6_r <= side5_r;
    end
  end

  // ---------------- square root ----------------
  logic [30:0] root;
  side_t       sided_r [0:SQRT_STAGES-1];

  q2e_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (rad6_r),
    .root (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      sided_r[0] <= side6_r;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sided_r[k] <= sided_r[k-1];
      end
    end
  end

  // ---------------- three atan2 units ----------------
  side_t                  sq_side;
  logic signed [OP_W-1:0] pitch_y, pitch_x;
  logic signed [15:0]     pitch_ang, heading_ang, bank_ang;
  lock_t                  lockd_r [0:CORDIC_LAT-1];

  assign sq_side = sided_r[SQRT_STAGES-1];
  assign pitch_y = OP_W'(sq_side.s);
  assign pitch_x = $signed({3'b0, root});

  q2e_cordic #(.ITER(ANGLE_ITERATIONS)) u_pitch (
    .clk (clk), .en (en), .y_in (pitch_y), .x_in (pitch_x), .angle (pitch_ang)
  );

  q2e_cordic #(.ITER(ANGLE_ITERATIONS)) u_heading (
    .clk (clk), .en (en), .y_in (sq_side.hy), .x_in (sq_side.hx), .angle (heading_ang)
  );

  q2e_cordic #(.ITER(ANGLE_ITERATIONS)) u_bank (
    .clk (clk), .en (en), .y_in (sq_side.by), .x_in (sq_side.bx), .angle (bank_ang)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      lockd_r[0] <= '{lock: sq_side.lock, plock: sq_side.plock};
      for (int k = 1; k < CORDIC_LAT; k++) begin
        lockd_r[k] <= lockd_r[k-1];
      end
    end
  end

  // ---------------- output register ----------------
  lock_t              lk;
  logic signed [15:0] pitch_r, heading_r, bank_r;
  logic               lock_r;

  assign lk = lockd_r[CORDIC_LAT-1];

  always_ff @(posedge clk) begin
    if (en) begin
      pitch_r   <= lk.lock ? lk.plock : pitch_ang;
      heading_r <= heading_ang;
      bank_r    <= lk.lock ? 16'sd0 : bank_ang;
      lock_r    <= lk.lock;
    end
  end

  assign out_valid         = valid_r[LAT-1];
  assign out_pitch_angle   = pitch_r;
  assign out_heading_angle = heading_r;
  assign out_bank_angle    = bank_r;
  assign out_gimbal_lock   = lock_r;

`ifndef SYNTHESIS
  a_lock_bank_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gimbal_lock |-> out_bank_angle == 16'sd0)
    else $error("bank not zero under gimbal lock");

  a_lock_pitch_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_gimbal_lock |->
      (out_pitch_angle <= 16'sd16384) && (out_pitch_angle >= -16'sd16384))
    else $error("locked pitch beyond a quarter turn");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pitch_angle)
      && $stable(out_heading_angle) && $stable(out_bank_angle))
    else $error("result changed under stall");

  a_stall_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow the output");
`endif

endmodule

// File: sim/q2e_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// q2e_checker
// Watches the quaternion and angle channels and the register port of the
// quaternion to Euler angle converter. It computes the expected angles for
// every accepted request and compares each returned result, field by field.
// ----------------------------------------------------------------------------
module q2e_checker #(
  parameter int ANGLE_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [15:0] out_pitch_angle,
  input  logic signed [15:0] out_heading_angle,
  input  logic signed [15:0] out_bank_angle,
  input  logic               out_gimbal_lock,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output int                 errors,
  output int                 pending
);
  import q2e_pkg::*;

  typedef struct packed {
    logic [15:0] pitch;
    logic [15:0] heading;
    logic [15:0] bank;
    logic        lock;
  } angles_t;

  localparam longint ONE = 64'sd1 <<< 30;
  localparam longint HALF = 64'sd1 <<< 29;

  logic        dir_q;
  logic [14:0] thresh_q;
  angles_t     angles_q[$];

  function automatic longint atan_step(int i);
    case (i)
      0:  return 64'h20000000;
      1:  return 64'h12E4051E;
      2:  return 64'h09FB385B;
      3:  return 64'h051111D4;
      4:  return 64'h028B0D43;
      5:  return 64'h0145D7E1;
      6:  return 64'h00A2F61E;
      7:  return 64'h00517C55;
      8:  return 64'h0028BE53;
      9:  return 64'h00145F2F;
      10: return 64'h000A2F98;
      11: return 64'h000517CC;
      12: return 64'h00028BE6;
      13: return 64'h000145F3;
      14: return 64'h0000A2FA;
      15: return 64'h0000517D;
      16: return 64'h000028BE;
      17: return 64'h0000145F;
      18: return 64'h00000A30;
      19: return 64'h00000518;
      20: return 64'h0000028C;
      21: return 64'h00000146;
      22: return 64'h000000A3;
      23: return 64'h00000051;
      default: return 0;
    endcase
  endfunction

  function automatic logic [15:0] vector_angle(longint y, longint x);
    longint acc, t, dx, dy;
    logic [63:0] r;
    acc = 0;
    if (x == 0 && y == 0) return 16'd0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; acc = ONE;
      end else begin
        x = -y; y = t; acc = -ONE;
      end
    end
    for (int i = 0; i < ANGLE_ITERATIONS && i < 24; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y < 0) begin
        x -= dx; y += dy; acc -= atan_step(i);
      end else begin
        x += dx; y -= dy; acc += atan_step(i);
      end
    end
    r = (acc + 64'sd32768) >>> 16;
    return r[15:0];
  endfunction

  function automatic longint floor_sqrt(logic [63:0] v);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  function automatic angles_t euler_of(longint w, longint x, longint y, longint z);
    angles_t a;
    longint s, mag, p;
    s = dir_q ? -2 * (y * z + w * x) : -2 * (y * z - w * x);
    if (s > ONE) s = ONE;
    if (s < -ONE) s = -ONE;
    mag = s < 0 ? -s : s;
    a.lock = mag > (longint'(thresh_q) <<< 15);
    if (a.lock) begin
      p = ((mag <<< 14) + HALF) >>> 30;
      a.pitch = s < 0 ? 16'(-p) : 16'(p);
      a.heading = vector_angle(dir_q ? (-x * z - w * y) : (w * y - x * z),
                               HALF - y * y - z * z);
      a.bank = 16'd0;
    end else begin
      a.pitch = vector_angle(s, floor_sqrt(64'(ONE * ONE - mag * mag)));
      a.heading = vector_angle(dir_q ? (x * z - w * y) : (x * z + w * y),
                               HALF - x * x - y * y);
      a.bank = vector_angle(dir_q ? (x * y - w * z) : (x * y + w * z),
                            HALF - x * x - z * z);
    end
    return a;
  endfunction

  assign pending = angles_q.size();

  always @(posedge clk) begin
    angles_t e, g;
    if (!rst_n) begin
      dir_q <= 1'b0;
      thresh_q <= THRESH_RESET;
      errors <= 0;
    end else begin
      if (psel && penable && pwrite) begin
        if (paddr[2] == REG_DIRECTION) dir_q <= pwdata[0];
        else thresh_q <= pwdata[14:0];
      end
      if (in_valid && !in_stall)
        angles_q.push_back(euler_of(in_quat_w, in_quat_x, in_quat_y, in_quat_z));
      if (out_valid && !out_stall) begin
        g = '{out_pitch_angle, out_heading_angle, out_bank_angle, out_gimbal_lock};
        if (angles_q.size() == 0) begin
          if (errors < 10) $display("unexpected result %h", g);
          errors <= errors + 1;
        end else begin
          e = angles_q.pop_front();
          if (e != g) begin
            if (errors < 10)
              $display("mismatch: exp p=%h h=%h b=%h l=%b got p=%h h=%h b=%h l=%b",
                       e.pitch, e.heading, e.bank, e.lock,
                       g.pitch, g.heading, g.bank, g.lock);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives quaternion requests and register writes into the converter with
// random gaps and output stalls; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
  import q2e_pkg::*;

  localparam int LATENCY = 6 + 31 + ANGLE_ITER_DEF + 2 + 1;
  localparam int LIMIT = 400000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic signed [15:0] in_quat_w = '0, in_quat_x = '0, in_quat_y = '0, in_quat_z = '0;
  logic out_stall = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic in_stall, out_valid, out_gimbal_lock, pready;
  logic signed [15:0] out_pitch_angle, out_heading_angle, out_bank_angle;
  logic [31:0] prdata;
  int errors, pending;
  int cycles = 0;
  bit hold_long = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  quaternion_to_euler_angles u_top (.*);

  q2e_checker #(.ANGLE_ITERATIONS(ANGLE_ITER_DEF)) u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // receiver: random stalls, occasionally a long hold-off
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_long) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        n = $urandom_range(0, 4);
        if ($urandom_range(0, 3) == 0) n = 0;
        if (n != 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
          out_stall <= 1'b0;
        end
      end
    end
  end

  task automatic reg_write(logic idx, logic [31:0] v);
    @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= {idx, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // in_valid stays high after an accept so back-to-back requests need no gap;
  // it drops only for a drawn gap or in drain
  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z,
                           bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 4) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_quat_w <= w; in_quat_x <= x; in_quat_y <= y; in_quat_z <= z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // quaternion with random components and sign pattern; sometimes pushed toward lock
  task automatic send_random(bit gaps);
    logic [15:0] w, x, y, z;
    int k;
    k = $urandom_range(0, 9);
    if (k < 2) begin
      w = 16'($urandom); x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
    end else if (k < 4) begin
      // gimbal region: w~x~y~z magnitude 0.5
      w = 16'(16384 + $urandom_range(0, 40) - 20);
      x = 16'(($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 40) - 20);
      y = 16'(($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 40) - 20);
      z = 16'(($urandom_range(0, 1) ? 16384 : -16384) + $urandom_range(0, 40) - 20);
    end else begin
      w = 16'($urandom_range(0, 32767) >> $urandom_range(0, 3));
      x = 16'($urandom_range(0, 23170) >> $urandom_range(0, 3));
      y = 16'($urandom_range(0, 23170) >> $urandom_range(0, 3));
      z = 16'($urandom_range(0, 16384) >> $urandom_range(0, 3));
      if ($urandom_range(0, 1)) x = -x;
      if ($urandom_range(0, 1)) y = -y;
      if ($urandom_range(0, 1)) z = -z;
      if ($urandom_range(0, 1)) w = -w;
    end
    send_quat(w, x, y, z, gaps);
  endtask

  initial begin
    logic [15:0] lim[6];
    lim = '{16'h8000, 16'h7FFF, 16'h0000, 16'h4000, 16'hC000, 16'hFFFF};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero, identity, exact locks, pi wrap
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_quat(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
    send_quat(16'h0000, 16'h0000, 16'h0000, 16'h7FFF, 1'b0);
    send_quat(16'h0000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
    send_quat(16'h0000, 16'h0000, 16'h7FFF, 16'h0000, 1'b0);
    send_quat(16'h5A82, 16'h5A82, 16'h0000, 16'h0000, 1'b0);
    send_quat(16'h5A82, 16'hA57E, 16'h0000, 16'h0000, 1'b0);
    send_quat(16'h4000, 16'h4000, 16'h4000, 16'h4000, 1'b0);
    send_quat(16'h4000, 16'hC000, 16'h4000, 16'h4000, 1'b0);
    for (int i = 0; i < 6; i++)
      send_quat(lim[i], lim[(i + 1) % 6], lim[(i + 2) % 6], lim[(i + 3) % 6], 1'b1);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_quat(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1);
    drain();

    // phases over direction and threshold settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      reg_write(REG_DIRECTION, ph[0] ? 32'hFFFF_FFFF : 32'h0);
      case (ph)
        0: reg_write(REG_THRESHOLD, 32'd32767);
        1: reg_write(REG_THRESHOLD, 32'd0);
        2: reg_write(REG_THRESHOLD, 32'hFFFF_0000 | 32'd23170);
        default: reg_write(REG_THRESHOLD, $urandom_range(0, 32767));
      endcase
      for (int i = 0; i < 110; i++) begin
        if (ph == 2 && i == 10) hold_long = 1'b1;
        if (ph == 2 && i == 90) hold_long = 1'b0;
        send_random(i % 40 >= 25 ? 1'b0 : 1'b1);
      end
      // pause until every result is back before the next setting
      drain();
    end
    drain();
    if (errors == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// File: quaternion_to_euler_angles.f
rtl/q2e_pkg.sv
rtl/q2e_sqrt.sv
rtl/q2e_cordic.sv
rtl/quaternion_to_euler_angles.sv
sim/q2e_checker.sv
sim/testbench.sv
